// ----- rtl/joint_force_pi_torque_controller_unit_macros.svh -----
// assertion macros for the joint force pi torque controller
// used by the top level; expects clk and rst_n in scope
`ifndef JOINT_FORCE_PI_TORQUE_CONTROLLER_UNIT_MACROS_SVH
`define JOINT_FORCE_PI_TORQUE_CONTROLLER_UNIT_MACROS_SVH

// consequent holds in the same cycle as the antecedent
`define JFPI_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define JFPI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/jfpi_pkg.sv -----
// shared types, constants and helpers for the joint force pi torque controller
// no dependencies
package jfpi_pkg;

  // default joint count
  localparam int NUM_JOINTS_DEF = 7;

  // 9.81 in Q.16
  localparam logic [19:0] GRAVITY_Q16 = 20'd642908;

  // configuration register indexes
  localparam int CFG_AW = 3;
  localparam logic [CFG_AW-1:0] CFG_TARGET_MASS   = 3'd0;
  localparam logic [CFG_AW-1:0] CFG_TARGET_PGAIN  = 3'd1;
  localparam logic [CFG_AW-1:0] CFG_TARGET_IGAIN  = 3'd2;
  localparam logic [CFG_AW-1:0] CFG_SMOOTH_GAIN   = 3'd3;
  localparam logic [CFG_AW-1:0] CFG_STEP_LIMIT    = 3'd4;

  // reset values of the registers
  localparam logic [16:0] SMOOTH_GAIN_RST = 17'd66;
  localparam logic [22:0] STEP_LIMIT_RST  = 23'd65536;

  // action codes
  localparam logic ACT_START  = 1'b0;
  localparam logic ACT_UPDATE = 1'b1;

  // main sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_FF,
    ST_ERR,
    ST_INT,
    ST_ACC,
    ST_KI,
    ST_SUM,
    ST_SMOOTH,
    ST_DONE
  } jfpi_state_t;

  // saturate to 24-bit signed
  function automatic logic signed [23:0] sat24(input logic signed [63:0] x);
    logic signed [23:0] r;
    if (x > 64'sd8388607) begin
      r = 24'sh7FFFFF;
    end else if (x < -64'sd8388608) begin
      r = 24'sh800000;
    end else begin
      r = x[23:0];
    end
    return r;
  endfunction

  // saturate to 32-bit signed
  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (x < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/jfpi_jmem.sv -----
// per-joint state memory: bias torque and error integral, registered read
// uses jfpi_pkg only indirectly through the top level parameters
module jfpi_jmem #(
  parameter int NUM_JOINTS = 7,
  parameter int AW = 3
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 rd_en,
  input  logic [AW-1:0]        rd_addr,
  output logic signed [23:0]   rd_bias,
  output logic signed [31:0]   rd_integ,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  logic signed [23:0]   wr_bias,
  input  logic signed [31:0]   wr_integ
);

  logic [55:0]           mem [NUM_JOINTS];
  logic [NUM_JOINTS-1:0] vld_r;
  logic [55:0]           rdata_r;
  logic                  rvld_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_integ, wr_bias};
    end
  end

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
      rvld_r  <= vld_r[rd_addr];
    end
  end

  assign rd_bias  = rvld_r ? rdata_r[23:0]  : '0;
  assign rd_integ = rvld_r ? rdata_r[55:24] : '0;

endmodule

// ----- rtl/jfpi_gains.sv -----
// smoothed mass and gain registers with their first-order filter sequencer
// uses jfpi_pkg for nothing beyond widths set here
module jfpi_gains (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [15:0] tgt_mass,
  input  logic [15:0] tgt_pgain,
  input  logic [15:0] tgt_igain,
  input  logic [16:0] smooth_gain,
  output logic [31:0] mass,
  output logic [31:0] pgain,
  output logic [31:0] igain,
  output logic        busy
);

  logic [31:0] mass_r, pgain_r, igain_r;
  logic [1:0]  sel_r, sel_nxt;
  logic        ph_r, ph_nxt;
  logic        busy_r, busy_nxt;
  logic [48:0] a_r, b_r;
  logic [16:0] g_eff;
  logic [31:0] cur;
  logic [15:0] tgt;
  logic [49:0] acc;
  logic [31:0] smoothed;

  // gain above one acts as one
  assign g_eff = (smooth_gain > 17'd65536) ? 17'd65536 : smooth_gain;

  // pick the value under work
  always_comb begin
    unique case (sel_r)
      2'd0: begin
        cur = mass_r;
        tgt = tgt_mass;
      end
      2'd1: begin
        cur = pgain_r;
        tgt = tgt_pgain;
      end
      2'd2: begin
        cur = igain_r;
        tgt = tgt_igain;
      end
      default: begin
        cur = '0;
        tgt = '0;
      end
    endcase
  end

  // two products in the first phase, blend and round in the second
  always_ff @(posedge clk) begin
    if (busy_r && !ph_r) begin
      a_r <= g_eff * {tgt, 16'd0};
      b_r <= (17'd65536 - g_eff) * cur;
    end
  end

  assign acc      = {1'b0, a_r} + {1'b0, b_r} + 50'd32768;
  assign smoothed = acc[47:16];

  // sequencer over the three values
  always_comb begin
    sel_nxt  = sel_r;
    ph_nxt   = ph_r;
    busy_nxt = busy_r;
    if (start) begin
      sel_nxt  = 2'd0;
      ph_nxt   = 1'b0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      ph_nxt = ~ph_r;
      if (ph_r) begin
        if (sel_r == 2'd2) begin
          busy_nxt = 1'b0;
        end else begin
          sel_nxt = sel_r + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r   <= '0;
      ph_r    <= 1'b0;
      busy_r  <= 1'b0;
      mass_r  <= '0;
      pgain_r <= '0;
      igain_r <= '0;
    end else begin
      sel_r  <= sel_nxt;
      ph_r   <= ph_nxt;
      busy_r <= busy_nxt;
      if (busy_r && ph_r) begin
        unique case (sel_r)
          2'd0:    mass_r  <= smoothed;
          2'd1:    pgain_r <= smoothed;
          2'd2:    igain_r <= smoothed;
          default: ;
        endcase
      end
    end
  end

  assign mass  = mass_r;
  assign pgain = pgain_r;
  assign igain = igain_r;
  assign busy  = busy_r;

endmodule

// ----- rtl/joint_force_pi_torque_controller_unit.sv -----
// top level of the joint force pi torque controller: handshakes, config, sequencer
// uses jfpi_pkg, jfpi_jmem, jfpi_gains and the assertion macros header
//
// channel  | dir | handshake         | contents
// in       | in  | in_tvalid/tready  | tdata joint, jacobian, torques, tick; tuser action
// out      | out | out_tvalid/tready | tdata joint, command; tuser rate limited flag
// cfg      | in  | cfg_we            | register index and write data
//
// one word at a time; a start word or an out-of-range joint goes from read to done;
// an update steps through ff, err, int, acc, ki and sum, and after the last joint
// it waits in smooth for the gain filter (three values, each in two phases
// through the shared smoothing multipliers)
// an in-range word reads the joint memory once, writes it back before the next is taken
// reset restores config, clears smoothed gains and the memory valid bits at once
// a stalled out side holds the finished word and the sequencer until taken
`include "joint_force_pi_torque_controller_unit_macros.svh"

module joint_force_pi_torque_controller_unit #(
  parameter int NUM_JOINTS = jfpi_pkg::NUM_JOINTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // [2:0] joint_index, [21:3] jacobian_z, [45:22] measured_torque,
  // [69:46] gravity_torque, [93:70] prev_desired_torque, [109:94] tick_seconds
  input  logic [111:0]                in_tdata,
  // [0] action
  input  logic [0:0]                  in_tuser,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // [2:0] out_joint, [26:3] torque_command
  output logic [31:0]                 out_tdata,
  // [0] rate_limited
  output logic [0:0]                  out_tuser,
  input  logic                        cfg_we,
  input  logic [jfpi_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [22:0]                 cfg_wdata
);

  localparam int AW = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;

  // config registers
  logic [15:0] tgt_mass_r, tgt_pgain_r, tgt_igain_r;
  logic [16:0] smooth_gain_r;
  logic [22:0] step_lim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tgt_mass_r    <= '0;
      tgt_pgain_r   <= '0;
      tgt_igain_r   <= '0;
      smooth_gain_r <= jfpi_pkg::SMOOTH_GAIN_RST;
      step_lim_r    <= jfpi_pkg::STEP_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        jfpi_pkg::CFG_TARGET_MASS:  tgt_mass_r    <= cfg_wdata[15:0];
        jfpi_pkg::CFG_TARGET_PGAIN: tgt_pgain_r   <= cfg_wdata[15:0];
        jfpi_pkg::CFG_TARGET_IGAIN: tgt_igain_r   <= cfg_wdata[15:0];
        jfpi_pkg::CFG_SMOOTH_GAIN:  smooth_gain_r <= cfg_wdata[16:0];
        jfpi_pkg::CFG_STEP_LIMIT:   step_lim_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  jfpi_pkg::jfpi_state_t state_r, state_nxt;

  // captured word
  logic                act_r;
  logic [2:0]          joint_r;
  logic signed [18:0]  jz_r;
  logic signed [23:0]  meas_r, grav_r, prev_r;
  logic [15:0]         dt_r;

  logic in_acc;
  assign in_tready = (state_r == jfpi_pkg::ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      act_r   <= in_tuser[0];
      joint_r <= in_tdata[2:0];
      jz_r    <= in_tdata[21:3];
      meas_r  <= in_tdata[45:22];
      grav_r  <= in_tdata[69:46];
      prev_r  <= in_tdata[93:70];
      dt_r    <= in_tdata[109:94];
    end
  end

  // joint decode for the incoming and the captured word
  logic [4:0]    in_jext, jext;
  logic          in_jok, joint_ok, joint_last;
  logic [AW-1:0] in_addr, addr;

  assign in_jext    = {2'b00, in_tdata[2:0]};
  assign in_jok     = in_jext < 5'(NUM_JOINTS);
  assign in_addr    = in_jext[AW-1:0];
  assign jext       = {2'b00, joint_r};
  assign joint_ok   = jext < 5'(NUM_JOINTS);
  assign joint_last = jext == 5'(NUM_JOINTS - 1);
  assign addr       = jext[AW-1:0];

  // joint state memory
  logic signed [23:0] mem_bias, wr_bias;
  logic signed [31:0] mem_integ, wr_integ;
  logic               mem_we;

  jfpi_jmem #(
    .NUM_JOINTS (NUM_JOINTS),
    .AW         (AW)
  ) u_jmem (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (in_acc && in_jok),
    .rd_addr  (in_addr),
    .rd_bias  (mem_bias),
    .rd_integ (mem_integ),
    .wr_en    (mem_we),
    .wr_addr  (addr),
    .wr_bias  (wr_bias),
    .wr_integ (wr_integ)
  );

  // smoothed mass and gains
  logic [31:0] mass, pgain, igain;
  logic        gains_start, gains_busy;

  jfpi_gains u_gains (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (gains_start),
    .tgt_mass    (tgt_mass_r),
    .tgt_pgain   (tgt_pgain_r),
    .tgt_igain   (tgt_igain_r),
    .smooth_gain (smooth_gain_r),
    .mass        (mass),
    .pgain       (pgain),
    .igain       (igain),
    .busy        (gains_busy)
  );

  // datapath registers
  logic [51:0]         mprod_r;
  logic signed [23:0]  ext_r, ff_r, err_r;
  logic signed [47:0]  fprod_r;
  logic signed [40:0]  dprod_r;
  logic signed [56:0]  pprod_r;
  logic signed [31:0]  integ_r;
  logic signed [32:0]  pterm_r;
  logic signed [64:0]  iprod_r;
  logic signed [23:0]  res_cmd_r;
  logic                res_clip_r;

  // combinational pieces of each step
  logic signed [25:0]  ext_raw, bias_raw;
  logic [52:0]         fmag_sum;
  logic signed [28:0]  force_v;
  logic signed [32:0]  ff_shift;
  logic signed [23:0]  ff_v, err_v;
  logic signed [24:0]  dterm;
  logic signed [31:0]  integ_v;
  logic signed [32:0]  pterm_v;
  logic signed [40:0]  iterm;
  logic signed [23:0]  raw;
  logic signed [24:0]  diff, lim, cmd_wide;
  logic signed [23:0]  cmd_v;
  logic                clip_v;

  assign bias_raw = 26'(meas_r) - 26'(grav_r);
  assign ext_raw  = bias_raw - 26'(mem_bias);
  assign fmag_sum = {1'b0, mprod_r} + 53'd8388608;
  assign force_v  = -$signed({1'b0, fmag_sum[51:24]});
  assign ff_shift = 33'((fprod_r + 48'sd32768) >>> 16);
  assign ff_v     = jfpi_pkg::sat24(64'(ff_shift));
  assign err_v    = jfpi_pkg::sat24(64'(ff_v) - 64'(ext_r));
  assign dterm    = 25'((dprod_r + 41'sd32768) >>> 16);
  assign integ_v  = jfpi_pkg::sat32(64'(mem_integ) + 64'(dterm));
  assign pterm_v  = 33'((pprod_r + 57'sd8388608) >>> 24);
  assign iterm    = 41'((iprod_r + 65'sd8388608) >>> 24);
  assign raw      = jfpi_pkg::sat24(64'(ff_r) + 64'(pterm_r) + 64'(iterm));

  // step limit around the previous desired torque
  assign diff = 25'(raw) - 25'(prev_r);
  assign lim  = $signed({2'b00, step_lim_r});
  always_comb begin
    clip_v   = 1'b0;
    cmd_wide = 25'(raw);
    if (diff > lim) begin
      clip_v   = 1'b1;
      cmd_wide = 25'(prev_r) + lim;
    end else if (diff < -lim) begin
      clip_v   = 1'b1;
      cmd_wide = 25'(prev_r) - lim;
    end
  end
  assign cmd_v = cmd_wide[23:0];

  // step registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      jfpi_pkg::ST_READ: begin
        ext_r      <= jfpi_pkg::sat24(64'(ext_raw));
        mprod_r    <= mass * jfpi_pkg::GRAVITY_Q16;
        res_cmd_r  <= '0;
        res_clip_r <= 1'b0;
      end
      jfpi_pkg::ST_FF: begin
        fprod_r <= jz_r * force_v;
      end
      jfpi_pkg::ST_ERR: begin
        ff_r  <= ff_v;
        err_r <= err_v;
      end
      jfpi_pkg::ST_INT: begin
        dprod_r <= $signed({1'b0, dt_r}) * err_r;
        pprod_r <= $signed({1'b0, pgain}) * err_r;
      end
      jfpi_pkg::ST_ACC: begin
        integ_r <= integ_v;
        pterm_r <= pterm_v;
      end
      jfpi_pkg::ST_KI: begin
        iprod_r <= $signed({1'b0, igain}) * integ_r;
      end
      jfpi_pkg::ST_SUM: begin
        res_cmd_r  <= cmd_v;
        res_clip_r <= clip_v;
      end
      default: ;
    endcase
  end

  // memory write back: bias capture on start, integral on update
  always_comb begin
    mem_we   = 1'b0;
    wr_bias  = mem_bias;
    wr_integ = integ_r;
    if (state_r == jfpi_pkg::ST_READ && act_r == jfpi_pkg::ACT_START && joint_ok) begin
      mem_we   = 1'b1;
      wr_bias  = jfpi_pkg::sat24(64'(bias_raw));
      wr_integ = '0;
    end else if (state_r == jfpi_pkg::ST_SUM) begin
      mem_we = 1'b1;
    end
  end

  assign gains_start = (state_r == jfpi_pkg::ST_SUM) && joint_last;

  // output register
  logic        out_tvalid_r, out_load;
  logic [2:0]  out_joint_r;
  logic [23:0] out_cmd_r;
  logic        out_clip_r;

  assign out_load = (state_r == jfpi_pkg::ST_DONE) && (!out_tvalid_r || out_tready);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      jfpi_pkg::ST_IDLE:   if (in_acc) state_nxt = jfpi_pkg::ST_READ;
      jfpi_pkg::ST_READ: begin
        if (act_r == jfpi_pkg::ACT_UPDATE && joint_ok) begin
          state_nxt = jfpi_pkg::ST_FF;
        end else begin
          state_nxt = jfpi_pkg::ST_DONE;
        end
      end
      jfpi_pkg::ST_FF:     state_nxt = jfpi_pkg::ST_ERR;
      jfpi_pkg::ST_ERR:    state_nxt = jfpi_pkg::ST_INT;
      jfpi_pkg::ST_INT:    state_nxt = jfpi_pkg::ST_ACC;
      jfpi_pkg::ST_ACC:    state_nxt = jfpi_pkg::ST_KI;
      jfpi_pkg::ST_KI:     state_nxt = jfpi_pkg::ST_SUM;
      jfpi_pkg::ST_SUM: begin
        state_nxt = joint_last ? jfpi_pkg::ST_SMOOTH : jfpi_pkg::ST_DONE;
      end
      jfpi_pkg::ST_SMOOTH: if (!gains_busy) state_nxt = jfpi_pkg::ST_DONE;
      jfpi_pkg::ST_DONE:   if (out_load) state_nxt = jfpi_pkg::ST_IDLE;
      default:             state_nxt = jfpi_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= jfpi_pkg::ST_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_joint_r <= joint_r;
      out_cmd_r   <= res_cmd_r;
      out_clip_r  <= res_clip_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {5'd0, out_cmd_r, out_joint_r};
  assign out_tuser  = out_clip_r;

  // checks on the sequencer
  `JFPI_ASSERT_NEXT(a_accept_reads, in_tvalid && in_tready, state_r == jfpi_pkg::ST_READ, "accepted word did not start a read")
  `JFPI_ASSERT_SAME(a_mem_write_state, mem_we, state_r == jfpi_pkg::ST_READ || state_r == jfpi_pkg::ST_SUM, "memory written outside read or sum")
  `JFPI_ASSERT_SAME(a_smooth_last, gains_start, act_r == jfpi_pkg::ACT_UPDATE && joint_last, "gain filter started off the last joint update")
  `JFPI_ASSERT_SAME(a_out_from_done, $rose(out_tvalid_r), $past(state_r) == jfpi_pkg::ST_DONE, "result shown without passing done")

endmodule
